[hw/rtl/pip_pkg.sv]
package pip_pkg;

  localparam int COORD_BITS  = 16;
  localparam int MAX_CORNERS = 64;
  localparam int ADDR_W      = $clog2(MAX_CORNERS);
  localparam int CNT_W       = $clog2(MAX_CORNERS + 1);
  localparam int DIFF_W      = COORD_BITS + 1;
  localparam int PROD_W      = 2 * DIFF_W;

  localparam logic MODE_WRITE = 1'b0;
  localparam logic MODE_QUERY = 1'b1;

  typedef logic signed [COORD_BITS-1:0] coord_t;

  // one corner read from the store, handed to the edge pipeline
  typedef struct packed {
    logic   vld;
    logic   first;  // corner n-1, only seeds the previous-corner register
    coord_t x;
    coord_t y;
  } pip_edge_req_t;

  typedef struct packed {
    logic busy;  // any edge still in flight
    logic hit;   // an edge crosses left of the point
  } pip_edge_sts_t;

endpackage

[hw/rtl/pip_edge.sv]
module pip_edge (
  input  logic                   clk,
  input  logic                   rst_n,
  input  pip_pkg::pip_edge_req_t req,
  input  pip_pkg::coord_t        px,
  input  pip_pkg::coord_t        py,
  output pip_pkg::pip_edge_sts_t sts
);
  import pip_pkg::*;

  coord_t                    prev_x_r;
  coord_t                    prev_y_r;

  coord_t                    xi;
  coord_t                    yi;
  coord_t                    xj;
  coord_t                    yj;
  logic                      straddle;
  logic signed [DIFF_W-1:0]  dy_nxt;
  logic signed [DIFF_W-1:0]  dx_nxt;
  logic signed [DIFF_W-1:0]  t_nxt;
  logic signed [DIFF_W-1:0]  u_nxt;

  logic                      s1_vld_r;
  logic signed [DIFF_W-1:0]  dy_r;
  logic signed [DIFF_W-1:0]  dx_r;
  logic signed [DIFF_W-1:0]  t_r;
  logic signed [DIFF_W-1:0]  u_r;

  logic                      s2_vld_r;
  logic                      dy_pos_r;
  logic signed [PROD_W-1:0]  pa_r;
  logic signed [PROD_W-1:0]  pb_r;

  logic                      hit_r;
  logic                      left;

  always_comb begin
    xi = $signed(req.x);
    yi = $signed(req.y);
    xj = prev_x_r;
    yj = prev_y_r;
    // half-open rule on the point's y
    straddle = ((yi < py) && (yj >= py)) || ((yj < py) && (yi >= py));
    dy_nxt = DIFF_W'(yj) - DIFF_W'(yi);
    dx_nxt = DIFF_W'(xj) - DIFF_W'(xi);
    t_nxt  = DIFF_W'(py) - DIFF_W'(yi);
    u_nxt  = DIFF_W'(px) - DIFF_W'(xi);
  end

  // crossing left of px: t*dx/dy < u, sign of dy picks the direction
  assign left = dy_pos_r ? (pa_r < pb_r) : (pb_r < pa_r);

  always_ff @(posedge clk) begin
    if (req.vld) begin
      prev_x_r <= xi;
      prev_y_r <= yi;
    end
    dy_r     <= dy_nxt;
    dx_r     <= dx_nxt;
    t_r      <= t_nxt;
    u_r      <= u_nxt;
    pa_r     <= t_r * dx_r;
    pb_r     <= u_r * dy_r;
    dy_pos_r <= !dy_r[DIFF_W-1];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
      s2_vld_r <= 1'b0;
      hit_r    <= 1'b0;
    end else begin
      s1_vld_r <= req.vld && !req.first && straddle;
      s2_vld_r <= s1_vld_r;
      hit_r    <= s2_vld_r && left;
    end
  end

  assign sts.busy = s1_vld_r || s2_vld_r || hit_r;
  assign sts.hit  = hit_r;

endmodule

[hw/rtl/point_in_polygon_test.sv]
// Even-odd point-in-polygon test. A request with tuser = 0 stores one corner
// at vertex_index and gives no result. A request with tuser = 1 tests the
// point (coord_x, coord_y) against the corner_count corners in slots 0..n-1
// (n capped at 64) and returns one result, 1 when the point is inside. The
// time a query takes is set by the single read port of the corner memory,
// which delivers one corner per cycle (n + 1 reads, the last corner first to
// close the ring), and by an edge pipeline (difference, product and hit
// registers) with a 17x17 multiply that then drains. With fewer than three
// corners the query skips the corner walk and answers 0. One request is in
// work at a time; the next one is taken while a finished result waits in the
// output register. Query only slots that were written. The user must write
// corner_count only while idle; the block itself does not enforce it.
module point_in_polygon_test (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [39:0] in_tdata,   // vertex_index[5:0], coord_x[21:6], coord_y[37:22], zero
  input  logic        in_tuser,   // mode
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata,  // inside_res[0], zero
  input  logic        cfg_wr_en,
  input  logic [6:0]  cfg_wr_data // corner_count
);
  import pip_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_RUN   = 3'b010,
    ST_DRAIN = 3'b100
  } state_t;

  state_t                   state_r;
  logic [CNT_W-1:0]         corner_count_r;
  logic [CNT_W-1:0]         n_r;
  logic [CNT_W-1:0]         k_r;
  logic [CNT_W-1:0]         n_nxt;
  coord_t                   px_r;
  coord_t                   py_r;
  logic                     odd_r;
  logic                     out_tvalid_r;
  logic                     inside_r;

  logic [2*COORD_BITS-1:0]  mem [MAX_CORNERS];
  logic [2*COORD_BITS-1:0]  rd_data_r;
  logic                     rd_vld_r;
  logic                     rd_first_r;
  logic [ADDR_W-1:0]        rd_addr;

  logic [5:0]               in_index;
  coord_t                   in_x;
  coord_t                   in_y;
  logic                     in_acc;
  logic                     done;

  pip_edge_req_t            edge_req;
  pip_edge_sts_t            edge_sts;

  assign in_index = in_tdata[5:0];
  assign in_x     = in_tdata[21:6];
  assign in_y     = in_tdata[37:22];

  assign in_tready = (state_r == ST_IDLE);
  assign in_acc    = in_tvalid && in_tready;

  assign n_nxt = (corner_count_r > CNT_W'(MAX_CORNERS)) ? CNT_W'(MAX_CORNERS)
                                                        : corner_count_r;

  // ring order: corner n-1 first, then 0..n-1
  assign rd_addr = (k_r == '0) ? ADDR_W'(n_r - 1'b1) : ADDR_W'(k_r - 1'b1);

  assign done = !rd_vld_r && !edge_sts.busy && (!out_tvalid_r || out_tready);

  always_ff @(posedge clk) begin
    if (in_acc && (in_tuser == MODE_WRITE)) begin
      mem[in_index[ADDR_W-1:0]] <= {in_y, in_x};
    end
    if (state_r == ST_RUN) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign edge_req.vld   = rd_vld_r;
  assign edge_req.first = rd_first_r;
  assign edge_req.x     = rd_data_r[COORD_BITS-1:0];
  assign edge_req.y     = rd_data_r[2*COORD_BITS-1:COORD_BITS];

  pip_edge u_edge (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (edge_req),
    .px    (px_r),
    .py    (py_r),
    .sts   (edge_sts)
  );

  always_ff @(posedge clk) begin
    if (in_acc && (in_tuser == MODE_QUERY)) begin
      px_r <= in_x;
      py_r <= in_y;
      n_r  <= n_nxt;
    end
    if ((state_r == ST_DRAIN) && done) begin
      inside_r <= odd_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= ST_IDLE;
      corner_count_r <= '0;
      k_r            <= '0;
      odd_r          <= 1'b0;
      rd_vld_r       <= 1'b0;
      rd_first_r     <= 1'b0;
      out_tvalid_r   <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        corner_count_r <= cfg_wr_data;
      end
      if (out_tvalid_r && out_tready) begin
        out_tvalid_r <= 1'b0;
      end
      if (edge_sts.hit) begin
        odd_r <= !odd_r;
      end
      rd_vld_r   <= (state_r == ST_RUN);
      rd_first_r <= (state_r == ST_RUN) && (k_r == '0);
      unique case (state_r)
        ST_IDLE: begin
          if (in_acc && (in_tuser == MODE_QUERY)) begin
            k_r     <= '0;
            odd_r   <= 1'b0;
            state_r <= (n_nxt >= CNT_W'(3)) ? ST_RUN : ST_DRAIN;
          end
        end
        ST_RUN: begin
          k_r <= k_r + 1'b1;
          if (k_r == n_r) begin
            state_r <= ST_DRAIN;
          end
        end
        ST_DRAIN: begin
          if (done) begin
            out_tvalid_r <= 1'b1;
            state_r      <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = {7'b0, inside_r};

  a_hit_in_query: assert property (@(posedge clk) disable iff (!rst_n)
    edge_sts.hit |-> (state_r != ST_IDLE))
    else $error("edge hit outside a query");

  a_run_bounds: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_RUN) |-> ((k_r <= n_r) && (n_r >= CNT_W'(3))))
    else $error("corner walk out of range");

  a_result_after_drain: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid_r) |-> $past(!rd_vld_r && !edge_sts.busy))
    else $error("result loaded with edges in flight");

  a_no_read_idle: assert property (@(posedge clk) disable iff (!rst_n)
    rd_vld_r |-> (state_r != ST_IDLE) && $past(state_r == ST_RUN))
    else $error("corner read outside a walk");

endmodule

[test/point_in_polygon_test_test.sv]
`timescale 1ns / 1ps

module point_in_polygon_test_test;
  import pip_pkg::*;

  localparam int LIMIT        = 1_000_000;
  localparam int ITEMS_TARGET = 1900;
  localparam int SETTLE       = 80;   // longest query (64 corners) plus margin
  localparam int HOLD_LEN     = 400;

  typedef enum logic [1:0] { ROW_CFG, ROW_WRITE, ROW_QUERY } row_kind_t;
  typedef enum logic [1:0] { EXP_MODEL, EXP_ZERO, EXP_ONE } exp_kind_t;
  typedef enum logic [2:0] { RX_ALWAYS, RX_HALF, RX_MOSTLY, RX_SPARSE, RX_PERIODIC } rx_mode_t;

  typedef struct packed {
    row_kind_t  kind;
    logic [6:0] cnt;
    logic [5:0] idx;
    coord_t     x;
    coord_t     y;
    exp_kind_t  want;
  } dir_row_t;

  localparam dir_row_t PLAN [25] = '{
    '{ROW_QUERY, 7'd0,   6'd0, 16'sd0,       16'sd0,       EXP_ZERO},   // right after reset
    '{ROW_CFG,   7'd2,   6'd0, 16'sd0,       16'sd0,       EXP_MODEL},
    '{ROW_WRITE, 7'd0,   6'd0, -16'sd100,    -16'sd100,    EXP_MODEL},
    '{ROW_WRITE, 7'd0,   6'd1, 16'sd100,     -16'sd100,    EXP_MODEL},
    '{ROW_QUERY, 7'd0,   6'd0, 16'sd0,       16'sd0,       EXP_ZERO},   // too few corners
    '{ROW_CFG,   7'd4,   6'd0, 16'sd0,       16'sd0,       EXP_MODEL},
    '{ROW_WRITE, 7'd0,   6'd2, 16'sd100,     16'sd100,     EXP_MODEL},
    '{ROW_WRITE, 7'd0,   6'd3, -16'sd100,    16'sd100,     EXP_MODEL},
    '{ROW_QUERY, 7'd0,   6'd0, 16'sd0,       16'sd0,       EXP_ONE},
    '{ROW_QUERY, 7'd0,   6'd0, 16'sd200,     16'sd0,       EXP_ZERO},
    '{ROW_QUERY, 7'd0,   6'd0, -16'sd100,    16'sd0,       EXP_MODEL},  // on left edge
    '{ROW_QUERY, 7'd0,   6'd0, 16'sd100,     16'sd0,       EXP_MODEL},  // on right edge
    '{ROW_QUERY, 7'd0,   6'd0, 16'sd0,       -16'sd100,    EXP_MODEL},  // bottom row
    '{ROW_QUERY, 7'd0,   6'd0, 16'sd0,       16'sd100,     EXP_MODEL},  // top row
    '{ROW_WRITE, 7'd0,   6'd0, 16'sh8000,    16'sh8000,    EXP_MODEL},
    '{ROW_WRITE, 7'd0,   6'd1, 16'sh7fff,    16'sh8000,    EXP_MODEL},
    '{ROW_WRITE, 7'd0,   6'd2, 16'sh7fff,    16'sh7fff,    EXP_MODEL},
    '{ROW_WRITE, 7'd0,   6'd3, 16'sh8000,    16'sh7fff,    EXP_MODEL},
    '{ROW_QUERY, 7'd0,   6'd0, 16'sd0,       16'sd0,       EXP_ONE},
    '{ROW_QUERY, 7'd0,   6'd0, 16'sh7fff,    16'sd0,       EXP_MODEL},
    '{ROW_QUERY, 7'd0,   6'd0, 16'sh8000,    16'sh8000,    EXP_MODEL},  // on a corner
    '{ROW_QUERY, 7'd0,   6'd0, 16'sh7fff,    16'sh7fff,    EXP_MODEL},
    '{ROW_CFG,   7'd3,   6'd0, 16'sd0,       16'sd0,       EXP_MODEL},
    '{ROW_QUERY, 7'd0,   6'd0, 16'sd100,     16'sd0,       EXP_MODEL},
    '{ROW_QUERY, 7'd0,   6'd0, -16'sd100,    16'sd0,       EXP_MODEL}
  };

  logic        clk         = 1'b0;
  logic        rst_n       = 1'b0;
  logic        in_tvalid   = 1'b0;
  logic        in_tready;
  logic [39:0] in_tdata    = '0;
  logic        in_tuser    = 1'b0;
  logic        out_tvalid;
  logic        out_tready  = 1'b0;
  logic [7:0]  out_tdata;
  logic        cfg_wr_en   = 1'b0;
  logic [6:0]  cfg_wr_data = '0;

  point_in_polygon_test dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  always #5 clk = ~clk;

  // predictor state
  coord_t     corner_x [MAX_CORNERS];
  coord_t     corner_y [MAX_CORNERS];
  logic [6:0] corner_cnt = '0;
  bit         inside_expected [$];

  int errors       = 0;
  int cycles       = 0;
  int items_sent   = 0;
  int n_writes     = 0;
  int n_queries    = 0;
  int n_inside     = 0;
  int n_settings   = 0;
  int results_seen = 0;
  int burst_left   = 0;

  function automatic bit poly_inside(coord_t px, coord_t py);
    int     n, j;
    bit     odd, left;
    longint xi, yi, xj, yj, dy, dx, t, u;
    odd = 1'b0;
    n = (corner_cnt > 7'd64) ? MAX_CORNERS : int'(corner_cnt);
    if (n >= 3) begin
      j = n - 1;
      for (int i = 0; i < n; i++) begin
        xi = corner_x[i];
        yi = corner_y[i];
        xj = corner_x[j];
        yj = corner_y[j];
        if ((yi < py && yj >= py) || (yj < py && yi >= py)) begin
          dy = yj - yi;
          dx = xj - xi;
          t  = py - yi;
          u  = px - xi;
          // crossing strictly left of px, sign of dy decides the direction
          left = (dy > 0) ? (t * dx < u * dy) : (u * dy < t * dx);
          if (left) odd = ~odd;
        end
        j = i;
      end
    end
    return odd;
  endfunction

  function automatic coord_t rand_coord(int scale);
    int v;
    case (scale)
      0:       v = int'($urandom_range(0, 65535));
      1:       v = int'($urandom_range(0, 40)) - 20;
      default: v = int'($urandom_range(0, 2000)) - 1000;
    endcase
    return coord_t'(v);
  endfunction

  task automatic send_req(input logic mode, input logic [5:0] idx, input coord_t x,
                          input coord_t y, input exp_kind_t want);
    int g, gap;
    if (burst_left == 0) begin
      g   = $urandom_range(0, 9);
      gap = (g < 4) ? 0 : (g < 8) ? $urandom_range(1, 4) : $urandom_range(10, 40);
      if (gap > 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(30, 80) : $urandom_range(1, 20);
    end
    burst_left--;
    in_tvalid <= 1'b1;
    in_tuser  <= mode;
    in_tdata  <= {2'b00, y, x, idx};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    items_sent++;
    if (mode == MODE_WRITE) begin
      corner_x[idx] = x;
      corner_y[idx] = y;
      n_writes++;
    end else begin
      n_queries++;
      if (want == EXP_MODEL) inside_expected.push_back(poly_inside(x, y));
      else inside_expected.push_back(want == EXP_ONE);
    end
  endtask

  task automatic drain();
    in_tvalid  <= 1'b0;
    burst_left = 0;
    while (inside_expected.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic set_count(input logic [6:0] v);
    drain();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en  <= 1'b0;
    corner_cnt = v;
    n_settings++;
  endtask

  // result side: stall pattern, long hold-offs, and the check
  rx_mode_t rx_mode   = RX_ALWAYS;
  int       rx_left   = 0;
  int       hold_left = 0;
  int       rx_tick   = 0;
  bit       want_bit;

  always @(posedge clk) begin
    if (rx_left == 0) begin
      rx_mode = rx_mode_t'($urandom_range(0, 4));
      rx_left = $urandom_range(64, 512);
    end else begin
      rx_left--;
    end
    rx_tick++;

    if (out_tvalid && out_tready) begin
      if (inside_expected.size() == 0) begin
        $display("%0t: result with nothing expected, expected none, got inside=%0b",
                 $time, out_tdata[0]);
        errors++;
      end else begin
        want_bit = inside_expected.pop_front();
        if (out_tdata[0] !== want_bit) begin
          $display("%0t: inside mismatch, expected %0b, got %0b", $time, want_bit, out_tdata[0]);
          errors++;
        end
        if (want_bit) n_inside++;
      end
      results_seen++;
      if (results_seen == 150 || results_seen == 900) hold_left = HOLD_LEN;
    end

    if (hold_left > 0) begin
      hold_left--;
      out_tready <= 1'b0;
    end else begin
      case (rx_mode)
        RX_ALWAYS:   out_tready <= 1'b1;
        RX_HALF:     out_tready <= 1'($urandom_range(0, 1));
        RX_MOSTLY:   out_tready <= ($urandom_range(0, 3) != 0);
        RX_SPARSE:   out_tready <= ($urandom_range(0, 3) == 0);
        default:     out_tready <= ((rx_tick % 7) < 3);
      endcase
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("%0t: timeout with %0d results outstanding", $time, inside_expected.size());
      $display("** point_in_polygon_test: FAILED **");
      $finish;
    end
  end

  initial begin
    int         phase, n_eff, scale, body, r, s, v;
    logic [6:0] cnt;
    coord_t     qx, qy;

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int k = 0; k < $size(PLAN); k++) begin
      case (PLAN[k].kind)
        ROW_CFG:   set_count(PLAN[k].cnt);
        ROW_WRITE: send_req(MODE_WRITE, PLAN[k].idx, PLAN[k].x, PLAN[k].y, EXP_MODEL);
        default:   send_req(MODE_QUERY, PLAN[k].idx, PLAN[k].x, PLAN[k].y, PLAN[k].want);
      endcase
    end

    phase = 0;
    while (items_sent < ITEMS_TARGET) begin
      case (phase)
        0: cnt = 7'd64;
        1: cnt = 7'd127;   // above the store size, capped
        2: cnt = 7'd0;
        default: begin
          r = $urandom_range(0, 99);
          if (r < 8)       cnt = 7'($urandom_range(0, 2));
          else if (r < 75) cnt = 7'($urandom_range(3, 8));
          else if (r < 92) cnt = 7'($urandom_range(9, 24));
          else if (r < 97) cnt = 7'($urandom_range(25, 64));
          else             cnt = 7'($urandom_range(65, 127));
        end
      endcase
      set_count(cnt);
      n_eff = (cnt > 7'd64) ? MAX_CORNERS : int'(cnt);
      scale = $urandom_range(0, 2);

      // fill every corner in use before any query reads it
      for (int k = 0; k < n_eff; k++)
        send_req(MODE_WRITE, 6'(k), rand_coord(scale), rand_coord(scale), EXP_MODEL);

      body = $urandom_range(20, 50);
      repeat (body) begin
        r = $urandom_range(0, 99);
        if (r < 12) begin
          send_req(MODE_WRITE, 6'($urandom_range(0, 63)), rand_coord(scale),
                   rand_coord(scale), EXP_MODEL);
        end else begin
          s = $urandom_range(0, 2);
          if (s == 0 && n_eff > 0) begin
            // same y as a corner, x on the corner or anywhere
            v  = $urandom_range(0, n_eff - 1);
            qy = corner_y[v];
            qx = $urandom_range(0, 1) ? corner_x[v] : rand_coord(scale);
          end else if (s == 1) begin
            qx = rand_coord(scale);
            qy = rand_coord(scale);
          end else begin
            qx = rand_coord(0);
            qy = rand_coord(0);
          end
          send_req(MODE_QUERY, 6'($urandom_range(0, 63)), qx, qy, EXP_MODEL);
        end
      end
      phase++;
    end

    drain();
    $display("run covered %0d vertex writes and %0d point queries (%0d inside)",
             n_writes, n_queries, n_inside);
    $display("over %0d corner-count settings, with two long result-side hold-offs", n_settings);
    if (errors == 0) begin
      $display("** point_in_polygon_test: PASSED **");
    end else begin
      $display("** point_in_polygon_test: FAILED **");
    end
    $finish;
  end

endmodule

[filelist.f]
hw/rtl/pip_pkg.sv
hw/rtl/pip_edge.sv
hw/rtl/point_in_polygon_test.sv
test/point_in_polygon_test_test.sv
